FILE: design/mpp_pkg.sv
// Shared constants, register indexes and pipeline tag type for the max-pool pyramid.
package mpp_pkg;

  localparam int MAX_COLS_DEF    = 1024;
  localparam int MAX_LEVELS_DEF  = 5;
  localparam int MAX_FACTOR_DEF  = 16;
  localparam int HEIGHT_BITS_DEF = 32;

  localparam int ROW_W        = 16;
  localparam int COLS_REG_W   = 11;
  localparam int LEVELS_W     = 3;
  localparam int FACTOR_W     = 5;
  localparam int LEVEL_W      = 3;
  localparam int CELL_COL_W   = 10;
  localparam int NUM_FACTORS  = 4;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 16;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_LEVELS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FACTOR_ONE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FACTOR_TWO   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FACTOR_THREE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FACTOR_FOUR  = 3'd6;

  typedef struct packed {
    logic have;
    logic frame_end;
  } tag_t;

endpackage

FILE: design/mpp_cfg.sv
// Configuration registers, clamping and per-level dimension sequencer (shared divider).
module mpp_cfg #(
  parameter int MAX_COLS   = mpp_pkg::MAX_COLS_DEF,
  parameter int MAX_LEVELS = mpp_pkg::MAX_LEVELS_DEF,
  parameter int MAX_FACTOR = mpp_pkg::MAX_FACTOR_DEF,
  localparam int LC_W      = $clog2(MAX_COLS + 1),
  localparam int LVL_W     = $clog2(MAX_LEVELS)
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wen_i,
  input  logic [mpp_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [mpp_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  output logic                              busy_o,
  output logic [mpp_pkg::LEVELS_W-1:0]      nl_o,
  output logic [mpp_pkg::FACTOR_W-1:0]      fk_o [MAX_LEVELS],
  output logic [LC_W-1:0]                   w_o [MAX_LEVELS],
  output logic [mpp_pkg::ROW_W-1:0]         h_o [MAX_LEVELS]
);

  localparam int FW    = mpp_pkg::FACTOR_W;
  localparam int RW    = mpp_pkg::ROW_W;
  localparam int STEP_W = $clog2(RW);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_LOAD = 3'b010,
    ST_DIV  = 3'b100
  } seq_state_t;

  logic [RW-1:0]                     rows_r;
  logic [mpp_pkg::COLS_REG_W-1:0]    cols_r;
  logic [mpp_pkg::LEVELS_W-1:0]      levels_r;
  logic [FW-1:0]                     factor_r [mpp_pkg::NUM_FACTORS];

  seq_state_t        state_r, state_nxt;
  logic [LVL_W-1:0]  lvl_r, lvl_nxt, lvl_up;
  logic [STEP_W-1:0] step_r;
  logic              last_step;

  logic [RW-1:0]     qw_r, qh_r, qw_nxt, qh_nxt;
  logic [FW-1:0]     rw_r, rh_r, rw_nxt, rh_nxt, dv_r;
  logic [FW:0]       tw, th;
  logic              gw, gh;

  logic [LC_W-1:0]   wq_r [MAX_LEVELS];
  logic [RW-1:0]     hq_r [MAX_LEVELS];
  logic [LC_W-1:0]   cols_eff;
  logic [RW-1:0]     rows_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r   <= RW'(1);
      cols_r   <= mpp_pkg::COLS_REG_W'(1);
      levels_r <= mpp_pkg::LEVELS_W'(1);
      for (int i = 0; i < mpp_pkg::NUM_FACTORS; i++) begin
        factor_r[i] <= FW'(2);
      end
    end else if (cfg_wen_i) begin
      case (cfg_idx_i)
        mpp_pkg::REG_GRID_ROWS:    rows_r      <= cfg_wdata_i[RW-1:0];
        mpp_pkg::REG_GRID_COLS:    cols_r      <= cfg_wdata_i[mpp_pkg::COLS_REG_W-1:0];
        mpp_pkg::REG_NUM_LEVELS:   levels_r    <= cfg_wdata_i[mpp_pkg::LEVELS_W-1:0];
        mpp_pkg::REG_FACTOR_ONE:   factor_r[0] <= cfg_wdata_i[FW-1:0];
        mpp_pkg::REG_FACTOR_TWO:   factor_r[1] <= cfg_wdata_i[FW-1:0];
        mpp_pkg::REG_FACTOR_THREE: factor_r[2] <= cfg_wdata_i[FW-1:0];
        mpp_pkg::REG_FACTOR_FOUR:  factor_r[3] <= cfg_wdata_i[FW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    rows_eff = (rows_r == '0) ? RW'(1) : rows_r;
    if (cols_r == '0) begin
      cols_eff = LC_W'(1);
    end else if (32'(cols_r) > MAX_COLS) begin
      cols_eff = LC_W'(MAX_COLS);
    end else begin
      cols_eff = LC_W'(cols_r);
    end
    if (levels_r == '0) begin
      nl_o = mpp_pkg::LEVELS_W'(1);
    end else if (32'(levels_r) > MAX_LEVELS) begin
      nl_o = mpp_pkg::LEVELS_W'(MAX_LEVELS);
    end else begin
      nl_o = levels_r;
    end
    fk_o[0] = FW'(1);
    for (int k = 1; k < MAX_LEVELS; k++) begin
      if (factor_r[k-1] == '0) begin
        fk_o[k] = FW'(1);
      end else if (32'(factor_r[k-1]) > MAX_FACTOR) begin
        fk_o[k] = FW'(MAX_FACTOR);
      end else begin
        fk_o[k] = factor_r[k-1];
      end
    end
  end

  assign lvl_up    = lvl_r + LVL_W'(1);
  assign last_step = (step_r == STEP_W'(RW - 1));

  always_comb begin
    tw     = {rw_r, qw_r[RW-1]};
    th     = {rh_r, qh_r[RW-1]};
    gw     = tw >= {1'b0, dv_r};
    gh     = th >= {1'b0, dv_r};
    qw_nxt = {qw_r[RW-2:0], gw};
    qh_nxt = {qh_r[RW-2:0], gh};
    rw_nxt = gw ? FW'(tw - {1'b0, dv_r}) : FW'(tw);
    rh_nxt = gh ? FW'(th - {1'b0, dv_r}) : FW'(th);
  end

  always_comb begin
    state_nxt = state_r;
    lvl_nxt   = lvl_r;
    case (state_r)
      ST_IDLE: ;
      ST_LOAD: state_nxt = ST_DIV;
      ST_DIV: begin
        if (last_step) begin
          if (lvl_r == LVL_W'(MAX_LEVELS - 2)) begin
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_LOAD;
            lvl_nxt   = lvl_up;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
        lvl_nxt   = '0;
      end
    endcase
    if (cfg_wen_i) begin
      state_nxt = ST_LOAD;
      lvl_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      lvl_r   <= '0;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      lvl_r   <= lvl_nxt;
      step_r  <= (state_r == ST_DIV) ? step_r + STEP_W'(1) : '0;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_LOAD: begin
        qw_r <= (lvl_r == '0) ? RW'(cols_eff) : RW'(wq_r[lvl_r]);
        qh_r <= (lvl_r == '0) ? rows_eff : hq_r[lvl_r];
        rw_r <= '0;
        rh_r <= '0;
        dv_r <= fk_o[lvl_up];
        if (lvl_r == '0) begin
          wq_r[0] <= cols_eff;
          hq_r[0] <= rows_eff;
        end
      end
      ST_DIV: begin
        qw_r <= qw_nxt;
        qh_r <= qh_nxt;
        rw_r <= rw_nxt;
        rh_r <= rh_nxt;
        if (last_step) begin
          wq_r[lvl_up] <= qw_nxt[LC_W-1:0];
          hq_r[lvl_up] <= qh_nxt;
        end
      end
      default: ;
    endcase
  end

  assign busy_o = (state_r != ST_IDLE);
  assign w_o    = wq_r;
  assign h_o    = hq_r;

endmodule

FILE: design/mpp_level.sv
// One pyramid level: block counters, running maximum and column-max line store.
module mpp_level #(
  parameter int MAX_COLS    = mpp_pkg::MAX_COLS_DEF,
  parameter int MAX_FACTOR  = mpp_pkg::MAX_FACTOR_DEF,
  parameter int HEIGHT_BITS = mpp_pkg::HEIGHT_BITS_DEF,
  localparam int LC_W       = $clog2(MAX_COLS + 1)
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              go_i,
  input  logic                              on_i,
  input  mpp_pkg::tag_t                     tag_i,
  input  logic signed [HEIGHT_BITS-1:0]     cur_i,
  input  logic [mpp_pkg::FACTOR_W-1:0]      fk_i,
  input  logic [LC_W-1:0]                   w_prev_i,
  input  logic [LC_W-1:0]                   w_cur_i,
  input  logic [mpp_pkg::ROW_W-1:0]         h_cur_i,
  output mpp_pkg::tag_t                     tag_o,
  output logic signed [HEIGHT_BITS-1:0]     cur_o,
  output logic [mpp_pkg::ROW_W-1:0]         row_o,
  output logic [LC_W-1:0]                   col_o
);

  localparam int AW    = $clog2(MAX_COLS);
  localparam int CIB_W = $clog2(MAX_FACTOR);
  localparam int CNT_W = ((CIB_W > mpp_pkg::FACTOR_W) ? CIB_W : mpp_pkg::FACTOR_W) + 1;
  localparam int POS_W = LC_W + mpp_pkg::FACTOR_W + 1;
  localparam int RW    = mpp_pkg::ROW_W;

  logic signed [HEIGHT_BITS-1:0] mem [MAX_COLS];
  logic signed [HEIGHT_BITS-1:0] rd_r;

  logic [LC_W-1:0]               lc_r, lc_nxt;
  logic [CIB_W-1:0]              cib_r, cib_nxt, rib_r, rib_nxt;
  logic [RW-1:0]                 lr_r, lr_nxt;
  logic signed [HEIGHT_BITS-1:0] rm_r, rm_nxt;

  logic                          active, row_end, blk_end, rib_end, wr, emit;
  logic [POS_W-1:0]              pos;
  logic signed [HEIGHT_BITS-1:0] line_new;

  always_comb begin
    active  = tag_i.have && on_i;
    pos     = POS_W'(lc_r) * POS_W'(fk_i) + POS_W'(cib_r);
    row_end = (w_prev_i == '0) || (pos >= POS_W'(w_prev_i) - POS_W'(1));
    blk_end = (CNT_W'(cib_r) + CNT_W'(1)) >= CNT_W'(fk_i);
    rib_end = (CNT_W'(rib_r) + CNT_W'(1)) >= CNT_W'(fk_i);
    rm_nxt  = ((cib_r == '0) || (cur_i > rm_r)) ? cur_i : rm_r;
    line_new = ((rib_r == '0) || (rm_nxt > rd_r)) ? rm_nxt : rd_r;
    wr      = active && blk_end && (lc_r < w_cur_i);
    emit    = wr && rib_end && (lr_r < h_cur_i);

    lc_nxt  = lc_r;
    cib_nxt = cib_r;
    rib_nxt = rib_r;
    lr_nxt  = lr_r;
    if (go_i) begin
      if (active) begin
        if (blk_end) begin
          cib_nxt = '0;
          lc_nxt  = lc_r + LC_W'(1);
        end else begin
          cib_nxt = cib_r + CIB_W'(1);
        end
        if (row_end) begin
          lc_nxt  = '0;
          cib_nxt = '0;
          if (rib_end) begin
            rib_nxt = '0;
            lr_nxt  = lr_r + RW'(1);
          end else begin
            rib_nxt = rib_r + CIB_W'(1);
          end
        end
      end
      if (tag_i.frame_end) begin
        lc_nxt  = '0;
        cib_nxt = '0;
        rib_nxt = '0;
        lr_nxt  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lc_r  <= '0;
      cib_r <= '0;
      rib_r <= '0;
      lr_r  <= '0;
    end else begin
      lc_r  <= lc_nxt;
      cib_r <= cib_nxt;
      rib_r <= rib_nxt;
      lr_r  <= lr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (go_i && active) begin
      rm_r <= rm_nxt;
    end
  end

  // read ahead at the next column; forward a same-cycle write
  always_ff @(posedge clk) begin
    if (go_i && wr) begin
      mem[lc_r[AW-1:0]] <= line_new;
    end
    if (go_i && wr && (lc_r[AW-1:0] == lc_nxt[AW-1:0])) begin
      rd_r <= line_new;
    end else begin
      rd_r <= mem[lc_nxt[AW-1:0]];
    end
  end

  always_comb begin
    tag_o.have      = emit;
    tag_o.frame_end = tag_i.frame_end;
    cur_o           = emit ? line_new : cur_i;
    row_o           = lr_r;
    col_o           = lc_r;
  end

endmodule

FILE: design/max_pool_pyramid.sv
// Max-pool pyramid top level: input counters, level pipeline and result serializer.
//
//   channel   dir   handshake               payload
//   in_       in    in_tvalid / in_tready   in_tdata: height
//   out_      out   out_tvalid / out_tready out_tdata: level, cell_row, cell_col, cell_max;
//                                           out_tlast: last
//   cfg_      in    cfg_wen                 cfg_idx, cfg_wdata
//
// One item per cycle while not busy and the output is not stalled; an item that
// causes n results holds the output until all n are taken. One stage per pooled
// level, each stage one line store read-modify-write with the next column read
// ahead into a register. After reset and after every register write the input is
// held off while the level sizes are recomputed by the divider.
// A stalled output backs up through the stage registers; empty stages keep accepting.
module max_pool_pyramid #(
  parameter int MAX_COLS    = mpp_pkg::MAX_COLS_DEF,
  parameter int MAX_LEVELS  = mpp_pkg::MAX_LEVELS_DEF,
  parameter int MAX_FACTOR  = mpp_pkg::MAX_FACTOR_DEF,
  parameter int HEIGHT_BITS = mpp_pkg::HEIGHT_BITS_DEF,
  localparam int IN_W       = ((HEIGHT_BITS + 7) / 8) * 8,
  localparam int OUT_RAW    = mpp_pkg::LEVEL_W + mpp_pkg::ROW_W + mpp_pkg::CELL_COL_W
                              + HEIGHT_BITS,
  localparam int OUT_W      = ((OUT_RAW + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wen,
  input  logic [mpp_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [mpp_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [IN_W-1:0]                 in_tdata,   // height
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [OUT_W-1:0]                out_tdata,  // level, cell_row, cell_col, cell_max
  output logic                            out_tlast
);

  localparam int NL      = MAX_LEVELS - 1;
  localparam int LC_W    = $clog2(MAX_COLS + 1);
  localparam int BC_W    = $clog2(MAX_COLS);
  localparam int RW      = mpp_pkg::ROW_W;
  localparam int ROW_LSB = mpp_pkg::LEVEL_W;
  localparam int COL_LSB = ROW_LSB + RW;
  localparam int MAX_LSB = COL_LSB + mpp_pkg::CELL_COL_W;

  logic                             busy;
  logic [mpp_pkg::LEVELS_W-1:0]     nl;
  logic [mpp_pkg::FACTOR_W-1:0]     fk [MAX_LEVELS];
  logic [LC_W-1:0]                  wd [MAX_LEVELS];
  logic [RW-1:0]                    hd [MAX_LEVELS];

  logic [BC_W-1:0]                  base_col_r;
  logic [RW-1:0]                    base_row_r;
  logic                             col_end, frame_end;

  logic [NL:0]                      mv;
  logic [NL-1:0]                    rdy, src_v, slot_v_r;

  mpp_pkg::tag_t                    st_tag_in [NL];
  mpp_pkg::tag_t                    st_tag_out [NL];
  logic signed [HEIGHT_BITS-1:0]    st_cur_in [NL];
  logic signed [HEIGHT_BITS-1:0]    st_cur_out [NL];
  logic [RW-1:0]                    st_row [NL];
  logic [LC_W-1:0]                  st_col [NL];

  mpp_pkg::tag_t                    slot_tag_r [NL];
  logic signed [HEIGHT_BITS-1:0]    slot_cur_r [NL];
  logic                             res_v_r   [NL][NL];
  logic [RW-1:0]                    res_row_r [NL][NL];
  logic [LC_W-1:0]                  res_col_r [NL][NL];
  logic signed [HEIGHT_BITS-1:0]    res_max_r [NL][NL];

  logic [NL-1:0]                    ser_pend_r, sel_oh, load_pend;
  logic [RW-1:0]                    ser_row_r [NL];
  logic [LC_W-1:0]                  ser_col_r [NL];
  logic signed [HEIGHT_BITS-1:0]    ser_max_r [NL];
  logic                             ser_last, ser_ready, out_fire, found;
  logic [mpp_pkg::LEVEL_W-1:0]      out_level;
  logic [RW-1:0]                    out_row;
  logic [LC_W-1:0]                  out_col;
  logic signed [HEIGHT_BITS-1:0]    out_max;

  mpp_cfg #(
    .MAX_COLS   (MAX_COLS),
    .MAX_LEVELS (MAX_LEVELS),
    .MAX_FACTOR (MAX_FACTOR)
  ) u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wen_i   (cfg_wen),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .busy_o      (busy),
    .nl_o        (nl),
    .fk_o        (fk),
    .w_o         (wd),
    .h_o         (hd)
  );

  // base raster position
  assign col_end   = LC_W'(base_col_r) >= (wd[0] - LC_W'(1));
  assign frame_end = col_end && (base_row_r >= (hd[0] - RW'(1)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_col_r <= '0;
      base_row_r <= '0;
    end else if (mv[0]) begin
      if (frame_end) begin
        base_col_r <= '0;
        base_row_r <= '0;
      end else if (col_end) begin
        base_col_r <= '0;
        base_row_r <= base_row_r + RW'(1);
      end else begin
        base_col_r <= base_col_r + BC_W'(1);
      end
    end
  end

  // stage advance chain
  always_comb begin
    mv[NL] = slot_v_r[NL-1] && ser_ready;
    for (int j = NL - 1; j >= 0; j--) begin
      rdy[j] = !slot_v_r[j] || mv[j+1];
      mv[j]  = src_v[j] && rdy[j];
    end
  end

  assign in_tready = !busy && rdy[0];

  for (genvar j = 0; j < NL; j++) begin : g_lvl
    if (j == 0) begin : g_src
      assign src_v[j]               = in_tvalid && !busy;
      assign st_tag_in[j].have      = 1'b1;
      assign st_tag_in[j].frame_end = frame_end;
      assign st_cur_in[j]           = in_tdata[HEIGHT_BITS-1:0];
    end else begin : g_src
      assign src_v[j]     = slot_v_r[j-1];
      assign st_tag_in[j] = slot_tag_r[j-1];
      assign st_cur_in[j] = slot_cur_r[j-1];
    end

    mpp_level #(
      .MAX_COLS    (MAX_COLS),
      .MAX_FACTOR  (MAX_FACTOR),
      .HEIGHT_BITS (HEIGHT_BITS)
    ) u_level (
      .clk      (clk),
      .rst_n    (rst_n),
      .go_i     (mv[j]),
      .on_i     (mpp_pkg::LEVELS_W'(j + 1) < nl),
      .tag_i    (st_tag_in[j]),
      .cur_i    (st_cur_in[j]),
      .fk_i     (fk[j+1]),
      .w_prev_i (wd[j]),
      .w_cur_i  (wd[j+1]),
      .h_cur_i  (hd[j+1]),
      .tag_o    (st_tag_out[j]),
      .cur_o    (st_cur_out[j]),
      .row_o    (st_row[j]),
      .col_o    (st_col[j])
    );

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        slot_v_r[j] <= 1'b0;
      end else if (mv[j]) begin
        slot_v_r[j] <= 1'b1;
      end else if (mv[j+1]) begin
        slot_v_r[j] <= 1'b0;
      end
    end

    always_ff @(posedge clk) begin
      if (mv[j]) begin
        slot_tag_r[j]   <= st_tag_out[j];
        slot_cur_r[j]   <= st_cur_out[j];
        res_v_r[j][j]   <= st_tag_out[j].have;
        res_row_r[j][j] <= st_row[j];
        res_col_r[j][j] <= st_col[j];
        res_max_r[j][j] <= st_cur_out[j];
      end
    end

    if (j > 0) begin : g_carry
      always_ff @(posedge clk) begin
        if (mv[j]) begin
          for (int m = 0; m < j; m++) begin
            res_v_r[j][m]   <= res_v_r[j-1][m];
            res_row_r[j][m] <= res_row_r[j-1][m];
            res_col_r[j][m] <= res_col_r[j-1][m];
            res_max_r[j][m] <= res_max_r[j-1][m];
          end
        end
      end
    end
  end

  // result serializer: lowest level first
  always_comb begin
    found     = 1'b0;
    sel_oh    = '0;
    out_level = '0;
    out_row   = '0;
    out_col   = '0;
    out_max   = '0;
    for (int m = 0; m < NL; m++) begin
      load_pend[m] = res_v_r[NL-1][m];
      if (ser_pend_r[m] && !found) begin
        sel_oh[m] = 1'b1;
        found     = 1'b1;
      end
    end
    for (int m = 0; m < NL; m++) begin
      if (sel_oh[m]) begin
        out_level = mpp_pkg::LEVEL_W'(m + 1);
        out_row   = ser_row_r[m];
        out_col   = ser_col_r[m];
        out_max   = ser_max_r[m];
      end
    end
    ser_last  = ((ser_pend_r & ~sel_oh) == '0);
    out_fire  = out_tvalid && out_tready;
    ser_ready = (ser_pend_r == '0) || (out_fire && ser_last);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ser_pend_r <= '0;
    end else if (mv[NL]) begin
      ser_pend_r <= load_pend;
    end else if (out_fire) begin
      ser_pend_r <= ser_pend_r & ~sel_oh;
    end
  end

  always_ff @(posedge clk) begin
    if (mv[NL]) begin
      for (int m = 0; m < NL; m++) begin
        ser_row_r[m] <= res_row_r[NL-1][m];
        ser_col_r[m] <= res_col_r[NL-1][m];
        ser_max_r[m] <= res_max_r[NL-1][m];
      end
    end
  end

  assign out_tvalid = (ser_pend_r != '0);
  assign out_tlast  = ser_last;

  always_comb begin
    out_tdata                           = '0;
    out_tdata[ROW_LSB-1:0]              = out_level;
    out_tdata[COL_LSB-1:ROW_LSB]        = out_row;
    out_tdata[MAX_LSB-1:COL_LSB]        = mpp_pkg::CELL_COL_W'(out_col);
    out_tdata[OUT_RAW-1:MAX_LSB]        = out_max;
  end

endmodule

FILE: tb/max_pool_pyramid_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for max_pool_pyramid: raster heights in, pooled pyramid cells out.
module max_pool_pyramid_tb;

  localparam int DRAIN_CYCLES = 12;
  localparam int RANDOM_ITEMS = 130;
  localparam int CYCLE_LIMIT  = 1000000;

  typedef struct packed {
    logic [2:0]  level;
    logic [15:0] row;
    logic [9:0]  col;
    logic [31:0] peak;
    logic        last;
  } cell_t;

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_wen;
  logic [mpp_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [mpp_pkg::CFG_DATA_W-1:0] cfg_wdata;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [31:0]                    in_tdata;   // height
  logic                           out_tvalid;
  logic                           out_tready;
  logic [63:0]                    out_tdata;  // level, cell_row, cell_col, cell_max
  logic                           out_tlast;

  logic [15:0]                    grid_rows_q  = 16'd1;
  logic [mpp_pkg::COLS_REG_W-1:0] grid_cols_q  = 11'd1;
  logic [mpp_pkg::LEVELS_W-1:0]   num_levels_q = 3'd1;
  logic [mpp_pkg::FACTOR_W-1:0]   factor_q [mpp_pkg::NUM_FACTORS] = '{5'd2, 5'd2, 5'd2, 5'd2};

  int unsigned        frame_row = 0;
  int unsigned        frame_col = 0;
  logic signed [31:0] strip_max [mpp_pkg::NUM_FACTORS] = '{0, 0, 0, 0};
  int unsigned        blk_col [mpp_pkg::NUM_FACTORS] = '{0, 0, 0, 0};
  int unsigned        blk_row [mpp_pkg::NUM_FACTORS] = '{0, 0, 0, 0};
  int unsigned        lvl_col [mpp_pkg::NUM_FACTORS] = '{0, 0, 0, 0};
  int unsigned        lvl_row [mpp_pkg::NUM_FACTORS] = '{0, 0, 0, 0};
  logic signed [31:0] col_max [mpp_pkg::NUM_FACTORS][mpp_pkg::MAX_COLS_DEF];

  cell_t cells_due [$];
  int    errors        = 0;
  int    cells_checked = 0;
  int    items_sent    = 0;
  int    hold_request  = 0;
  bit    no_idle       = 1'b0;

  max_pool_pyramid DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wen    (cfg_wen),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int unsigned clamp_u(input int unsigned v, input int unsigned lo,
                                          input int unsigned hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [31:0] pick_height();
    case ($urandom_range(0, 9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2, 3:    return 32'($urandom_range(0, 8)) - 32'd4;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [15:0] junk(input logic [15:0] mask);
    return ($urandom_range(0, 1) == 1) ? (16'($urandom()) & mask) : 16'h0000;
  endfunction

  function automatic logic [15:0] pick_factor();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 16'($urandom_range(1, 2)) | junk(16'hFFE0);
    if (r < 85) return 16'($urandom_range(2, 4)) | junk(16'hFFE0);
    if (r < 95) return 16'($urandom_range(5, 16));
    return 16'($urandom_range(0, 31)) | junk(16'hFFE0);
  endfunction

  task automatic clear_levels();
    int i;
    for (i = 0; i < mpp_pkg::NUM_FACTORS; i++) begin
      strip_max[i] = '0;
      blk_col[i]   = 0;
      blk_row[i]   = 0;
      lvl_col[i]   = 0;
      lvl_row[i]   = 0;
    end
  endtask

  // Fold one base sample up through the active levels it reaches, queue the cells it completes.
  task automatic predict_cells(input logic [31:0] h_in);
    int unsigned        rows, cols, nlev, fk, p, slot, k, i, n;
    int unsigned        wid [5];
    int unsigned        hgt [5];
    int unsigned        fac [5];
    logic signed [31:0] cur;
    bit                 carry, frame_done, row_done;
    cell_t              found [4];
    rows = (grid_rows_q == 0) ? 1 : grid_rows_q;
    cols = clamp_u(grid_cols_q, 1, mpp_pkg::MAX_COLS_DEF);
    nlev = clamp_u(num_levels_q, 1, mpp_pkg::MAX_LEVELS_DEF);
    cur = h_in;
    carry = 1'b1;
    n = 0;
    frame_done = (frame_col >= cols - 1) && (frame_row >= rows - 1);
    wid[0] = cols;
    hgt[0] = rows;
    fac[0] = 1;
    for (k = 1; k < 5; k++) begin
      fac[k] = clamp_u(factor_q[k-1], 1, mpp_pkg::MAX_FACTOR_DEF);
      wid[k] = wid[k-1] / fac[k];
      hgt[k] = hgt[k-1] / fac[k];
    end
    for (k = 1; k < nlev && carry; k++) begin
      i = k - 1;
      fk = fac[k];
      p = lvl_col[i] * fk + blk_col[i];
      row_done = (wid[k-1] == 0) || (p >= wid[k-1] - 1);
      carry = 1'b0;
      if (blk_col[i] == 0 || cur > strip_max[i]) strip_max[i] = cur;
      if (blk_col[i] + 1 >= fk) begin
        if (lvl_col[i] < wid[k]) begin
          slot = lvl_col[i];
          if (blk_row[i] == 0 || strip_max[i] > col_max[i][slot])
            col_max[i][slot] = strip_max[i];
          if (blk_row[i] + 1 >= fk && lvl_row[i] < hgt[k]) begin
            found[n].level = 3'(k);
            found[n].row   = 16'(lvl_row[i]);
            found[n].col   = 10'(lvl_col[i]);
            found[n].peak  = col_max[i][slot];
            found[n].last  = 1'b0;
            n++;
            cur = col_max[i][slot];
            carry = 1'b1;
          end
        end
        blk_col[i] = 0;
        lvl_col[i]++;
      end else begin
        blk_col[i]++;
      end
      if (row_done) begin
        lvl_col[i] = 0;
        blk_col[i] = 0;
        blk_row[i]++;
        if (blk_row[i] >= fk) begin
          blk_row[i] = 0;
          lvl_row[i] = (lvl_row[i] + 1) & 32'hFFFF;
        end
      end
    end
    if (frame_done) begin
      frame_row = 0;
      frame_col = 0;
      clear_levels();
    end else if (frame_col >= cols - 1) begin
      frame_col = 0;
      frame_row = (frame_row + 1) & 32'hFFFF;
    end else begin
      frame_col++;
    end
    for (k = 0; k < n; k++) begin
      found[k].last = (k == n - 1);
      cells_due.push_back(found[k]);
    end
  endtask

  task automatic report_mismatch(input string field, input logic [63:0] want,
                                 input logic [63:0] got);
    errors++;
    if (errors <= 40)
      $display("[%0t] cell %0d %s: expected %0h, got %0h", $time, cells_checked, field,
               want, got);
  endtask

  task automatic set_reg(input logic [mpp_pkg::CFG_IDX_W-1:0] idx,
                         input logic [mpp_pkg::CFG_DATA_W-1:0] value);
    case (idx)
      mpp_pkg::REG_GRID_ROWS:  grid_rows_q  = value;
      mpp_pkg::REG_GRID_COLS:  grid_cols_q  = value[mpp_pkg::COLS_REG_W-1:0];
      mpp_pkg::REG_NUM_LEVELS: num_levels_q = value[mpp_pkg::LEVELS_W-1:0];
      mpp_pkg::REG_FACTOR_ONE, mpp_pkg::REG_FACTOR_TWO,
      mpp_pkg::REG_FACTOR_THREE, mpp_pkg::REG_FACTOR_FOUR:
        factor_q[idx - mpp_pkg::REG_FACTOR_ONE] = value[mpp_pkg::FACTOR_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wen   <= 1'b0;
  endtask

  task automatic load_config(input logic [15:0] rows, input logic [15:0] cols,
                             input logic [15:0] levels, input logic [15:0] f1,
                             input logic [15:0] f2, input logic [15:0] f3,
                             input logic [15:0] f4);
    set_reg(mpp_pkg::REG_GRID_ROWS, rows);
    set_reg(mpp_pkg::REG_GRID_COLS, cols);
    set_reg(mpp_pkg::REG_NUM_LEVELS, levels);
    set_reg(mpp_pkg::REG_FACTOR_ONE, f1);
    set_reg(mpp_pkg::REG_FACTOR_TWO, f2);
    set_reg(mpp_pkg::REG_FACTOR_THREE, f3);
    set_reg(mpp_pkg::REG_FACTOR_FOUR, f4);
  endtask

  task automatic send_height(input logic [31:0] h);
    int gap;
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= h;
    do @(posedge clk); while (!in_tready);
    items_sent++;
    predict_cells(h);
  endtask

  // Hold the input, wait for every queued cell, then let the pipeline empty.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (cells_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic test_single_level();
    send_height(32'h7FFF_FFFF);
    send_height(32'h8000_0000);
    settle();
    set_reg(mpp_pkg::REG_NUM_LEVELS, 16'h0000);
    send_height(32'h0000_0000);
    settle();
  endtask

  task automatic test_full_cascade();
    load_config(16'h0000, 16'd4, 16'd5, 16'd0, 16'd1, 16'd0, 16'd1);
    send_height(32'h7FFF_FFFF);
    send_height(32'h8000_0000);
    send_height(32'hFFFF_FFFF);
    send_height(32'h0000_0000);
    settle();
  endtask

  task automatic test_uneven_blocks();
    load_config(16'd3, 16'd3, 16'hFFFF, 16'd2, 16'hFFFF, 16'd2, 16'd2);
    repeat (9) send_height(pick_height());
    settle();
  endtask

  task automatic test_midframe_limits();
    load_config(16'hFFFF, 16'hFC00, 16'd2, 16'd1, 16'd2, 16'd2, 16'd2);
    repeat (4) send_height(pick_height());
    settle();
    set_reg(mpp_pkg::REG_GRID_COLS, 16'd3);
    set_reg(mpp_pkg::REG_GRID_ROWS, 16'h0000);
    repeat (4) send_height(pick_height());
    settle();
  endtask

  task automatic test_stalled_sink();
    load_config(16'd2, 16'd8, 16'd5, 16'd1, 16'd1, 16'd1, 16'd1);
    hold_request = 200;
    no_idle = 1'b1;
    repeat (8) send_height(pick_height());
    settle();
    hold_request = 150;
    repeat (8) send_height(pick_height());
    no_idle = 1'b0;
    settle();
  endtask

  task automatic test_random_frames();
    int          goal, size, cut, r;
    logic [15:0] rows_v, cols_v, lev_v;
    goal = items_sent + RANDOM_ITEMS;
    while (items_sent < goal) begin
      r = $urandom_range(0, 99);
      rows_v = (r < 10) ? 16'h0000 : 16'($urandom_range(1, 8));
      cols_v = 16'($urandom_range((r < 5) ? 0 : 1, 16)) | junk(16'hF800);
      lev_v  = (r % 10 == 0) ? 16'($urandom_range(0, 7)) : 16'($urandom_range(2, 5));
      load_config(rows_v, cols_v, lev_v | junk(16'hFFF8), pick_factor(), pick_factor(),
                  pick_factor(), pick_factor());
      no_idle = ($urandom_range(0, 4) == 0);
      size = ((grid_rows_q == 0) ? 1 : grid_rows_q)
             * clamp_u(grid_cols_q, 1, mpp_pkg::MAX_COLS_DEF);
      repeat ($urandom_range(1, 2)) begin
        if (size > 1 && $urandom_range(0, 5) == 0) begin
          cut = $urandom_range(1, size - 1);
          repeat (cut) send_height(pick_height());
          settle();
          set_reg(mpp_pkg::REG_GRID_ROWS, 16'($urandom_range(0, 6)));
        end else begin
          repeat (size) send_height(pick_height());
        end
      end
      while (frame_row != 0 || frame_col != 0) send_height(pick_height());
      settle();
      no_idle = 1'b0;
    end
  endtask

  initial begin : result_sink
    int stall;
    stall = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        stall = hold_request;
        hold_request = 0;
      end else if (stall == 0 && !no_idle && $urandom_range(0, 2) == 0) begin
        stall = pick_gap();
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        stall--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin : result_check
    cell_t got, want;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        got.level = out_tdata[2:0];
        got.row   = out_tdata[18:3];
        got.col   = out_tdata[28:19];
        got.peak  = out_tdata[60:29];
        got.last  = out_tlast;
        if (cells_due.size() == 0) begin
          report_mismatch("unexpected cell", 64'd0, out_tdata);
        end else begin
          want = cells_due.pop_front();
          if (got.level !== want.level) report_mismatch("level", want.level, got.level);
          if (got.row !== want.row) report_mismatch("cell_row", want.row, got.row);
          if (got.col !== want.col) report_mismatch("cell_col", want.col, got.col);
          if (got.peak !== want.peak) report_mismatch("cell_max", want.peak, got.peak);
          if (got.last !== want.last) report_mismatch("last", want.last, got.last);
        end
        cells_checked++;
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    rst_n     <= 1'b0;
    cfg_wen   <= 1'b0;
    cfg_idx   <= mpp_pkg::REG_GRID_ROWS;
    cfg_wdata <= '0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_single_level();
    test_full_cascade();
    test_uneven_blocks();
    test_midframe_limits();
    test_stalled_sink();
    test_random_frames();
    settle();
    if (errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
